FILE: rtl/plf_pkg.sv
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types, register codes, limits and table builders for the power-law
// flow pipeline.
// ----------------------------------------------------------------------------
package plf_pkg;

    // Configuration port geometry: four registers at 8-byte spacing
    localparam int CFG_AW = 5;

    typedef enum logic [1:0] {
        REG_COEFF     = 2'd0,
        REG_EXPONENT  = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_SLOPE     = 2'd3
    } reg_idx_t;

    localparam logic [31:0] RST_COEFF     = 32'd16777216;
    localparam logic [15:0] RST_EXPONENT  = 16'd21299;
    localparam logic [30:0] RST_THRESHOLD = 31'd66;
    localparam logic [47:0] RST_SLOPE     = 48'h0001_0000_0000;

    localparam logic [15:0] EXP_MIN = 16'd16384;
    localparam logic [15:0] EXP_MAX = 16'd32768;

    localparam logic [47:0] MASK48   = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] FLIM_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] FLIM_NEG = 48'h8000_0000_0000;

    // Register values seen by the datapath (exponent already clamped)
    typedef struct packed {
        logic [31:0] coeff;
        logic [15:0] expn;
        logic [30:0] thr;
        logic [47:0] slope;
    } cfg_t;

    // Front end to log/exp section
    typedef struct packed {
        logic [31:0] x;
        logic        neg;
        logic [55:0] a;
        logic [51:0] g;
        logic        lin;
        logic        zero;
        logic [4:0]  e;
        logic [30:0] m;
    } front_t;

    // Log/exp section to back end
    typedef struct packed {
        logic        neg;
        logic        lin;
        logic        zero;
        logic [55:0] a;
        logic [47:0] lin_mag;
        logic [47:0] lin_slope;
        logic        lin_sat;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [6:0]  k1;
        logic [6:0]  k2;
    } lx_t;

    // Integer square root, digit by digit
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] num;
        logic [63:0] res;
        logic [63:0] bitv;
        num  = n;
        res  = 64'd0;
        bitv = 64'h4000_0000_0000_0000;
        for (int t = 0; t < 32; t++)
        begin
            if (num >= res + bitv)
            begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/2^b) in Q.24 by repeated squaring
    function automatic logic [63:0] lt_entry(input int i, input int b);
        logic [63:0] y;
        logic [63:0] acc;
        if (i == (1 << b))
            return 64'd1 << 24;
        y   = (64'd1 << 30) + (64'(i) << (30 - b));
        acc = 64'd0;
        for (int t = 0; t < 24; t++)
        begin
            y   = (y * y) >> 30;
            acc = acc << 1;
            if (y >= (64'd1 << 31))
            begin
                acc = acc | 64'd1;
                y   = y >> 1;
            end
        end
        return acc;
    endfunction

    // 2^(i/2^b) in Q.30 as a product of repeated square roots of two
    function automatic logic [63:0] et_entry(input int i, input int b);
        logic [63:0] root;
        logic [63:0] v;
        if (i == (1 << b))
            return 64'd1 << 31;
        root = 64'd1 << 31;
        v    = 64'd1 << 30;
        for (int j = 1; j <= b; j++)
        begin
            root = isqrt64(root << 30);
            if (((i >> (b - j)) & 1) != 0)
                v = (v * root) >> 30;
        end
        return v;
    endfunction

endpackage

FILE: rtl/plf_in_if.sv
// ----------------------------------------------------------------------------
// plf_in_if
// Input channel: pressure difference and density beats.
// ----------------------------------------------------------------------------
interface plf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pressure_diff;
    logic        [23:0] fluid_density;

    modport source (output valid, pressure_diff, fluid_density, input ready);
    modport sink   (input valid, pressure_diff, fluid_density, output ready);
endinterface

FILE: rtl/plf_out_if.sv
// ----------------------------------------------------------------------------
// plf_out_if
// Output channel: mass flow, slope and saturation flag beats.
// ----------------------------------------------------------------------------
interface plf_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] mass_flow;
    logic        [47:0] flow_slope;
    logic               saturated;

    modport source (output valid, mass_flow, flow_slope, saturated, input ready);
    modport sink   (input valid, mass_flow, flow_slope, saturated, output ready);
endinterface

FILE: rtl/plf_cfg.sv
// ----------------------------------------------------------------------------
// plf_cfg
// APB register file for coefficient, exponent, threshold and linear slope.
// ----------------------------------------------------------------------------
module plf_cfg
    import plf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [31:0] coeff_reg;
    logic [15:0] expn_reg;
    logic [30:0] thr_reg;
    logic [47:0] slope_reg;
    reg_idx_t    idx;
    logic        wr_en;

    assign idx    = reg_idx_t'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write registers on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= RST_COEFF;
            expn_reg  <= RST_EXPONENT;
            thr_reg   <= RST_THRESHOLD;
            slope_reg <= RST_SLOPE;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_COEFF:     coeff_reg <= pwdata[31:0];
                REG_EXPONENT:  expn_reg  <= pwdata[15:0];
                REG_THRESHOLD: thr_reg   <= pwdata[30:0];
                REG_SLOPE:     slope_reg <= pwdata[47:0];
                default:       coeff_reg <= coeff_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_COEFF:     prdata = {32'd0, coeff_reg};
            REG_EXPONENT:  prdata = {48'd0, expn_reg};
            REG_THRESHOLD: prdata = {33'd0, thr_reg};
            REG_SLOPE:     prdata = {16'd0, slope_reg};
            default:       prdata = 64'd0;
        endcase
    end

    // Clamp the exponent into its legal range
    always_comb
    begin
        cfg.coeff = coeff_reg;
        cfg.thr   = thr_reg;
        cfg.slope = slope_reg;
        if (expn_reg < EXP_MIN)
            cfg.expn = EXP_MIN;
        else if (expn_reg > EXP_MAX)
            cfg.expn = EXP_MAX;
        else
            cfg.expn = expn_reg;
    end

endmodule

FILE: rtl/plf_front.sv
// ----------------------------------------------------------------------------
// plf_front
// Two stages: magnitude and density products, then linear gain, zone
// decision and normalization of the pressure magnitude.
// ----------------------------------------------------------------------------
module plf_front
    import plf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pressure_diff,
    input  logic        [23:0] fluid_density,
    input  cfg_t               cfg,
    output logic               out_valid,
    input  logic               out_ready,
    output front_t             out_data
);

    localparam int NS = 2;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    // Stage 1 registers
    logic [31:0] s1_x_reg;
    logic        s1_neg_reg;
    logic [55:0] s1_p0_reg;
    logic [39:0] s1_p1_reg;
    logic [55:0] s1_a_reg;

    // Stage 2 registers
    front_t      s2_reg;

    logic [31:0] x_next;
    logic [71:0] p_sum;
    logic [4:0]  msb;
    logic [31:0] norm;

    // Stall chain: a stage loads when empty or when the next one loads
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        en[0]    = !v_reg[0] || en[1];
    end

    assign v_next    = {v_reg[NS-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_next[k];
            end
        end
    end

    // Stage 1: magnitude of dp, density products
    assign x_next = pressure_diff[31] ? (32'd0 - 32'(pressure_diff)) : 32'(pressure_diff);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_x_reg   <= x_next;
            s1_neg_reg <= pressure_diff[31];
            s1_p0_reg  <= fluid_density * cfg.slope[31:0];
            s1_p1_reg  <= fluid_density * cfg.slope[47:32];
            s1_a_reg   <= fluid_density * cfg.coeff;
        end
    end

    // Stage 2: linear gain, zone flags, leading-one search and normalize
    assign p_sum = {16'd0, s1_p0_reg} + {s1_p1_reg, 32'd0};

    always_comb
    begin
        msb = 5'd0;
        for (int b = 0; b < 32; b++)
        begin
            if (s1_x_reg[b])
                msb = 5'(b);
        end
        norm = s1_x_reg << (5'd31 - msb);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_reg.x    <= s1_x_reg;
            s2_reg.neg  <= s1_neg_reg;
            s2_reg.a    <= s1_a_reg;
            s2_reg.g    <= p_sum[71:20];
            s2_reg.lin  <= s1_x_reg < {1'b0, cfg.thr};
            s2_reg.zero <= s1_x_reg == 32'd0;
            s2_reg.e    <= msb;
            s2_reg.m    <= norm[31:1];
        end
    end

endmodule

FILE: rtl/plf_logexp.sv
// ----------------------------------------------------------------------------
// plf_logexp
// Six stages: table log2 of the pressure magnitude, scaling by the exponent,
// table exp2 of both powers; the linear-zone flow rides alongside.
// ----------------------------------------------------------------------------
module plf_logexp
    import plf_pkg::*;
#(
    parameter int POW_TABLE_INDEX_BITS = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    input  cfg_t   cfg,
    output logic   out_valid,
    input  logic   out_ready,
    output lx_t    out_data
);

    localparam int B     = POW_TABLE_INDEX_BITS;
    localparam int TSIZE = (1 << B) + 1;
    localparam int AW    = B + 1;
    localparam int RW    = 30 - B;
    localparam int FW    = 24 - B;
    localparam int NS    = 6;

    logic [24:0] lt_rom [TSIZE];
    logic [31:0] et_rom [TSIZE];

    for (genvar gi = 0; gi < TSIZE; gi++)
    begin : g_rom
        assign lt_rom[gi] = 25'(lt_entry(gi, B));
        assign et_rom[gi] = 32'(et_entry(gi, B));
    end

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    // Fields that travel unchanged through every stage
    typedef struct packed {
        logic        neg;
        logic        lin;
        logic        zero;
        logic [55:0] a;
    } carry_t;

    carry_t c3_reg, c4_reg, c5_reg, c6_reg, c7_reg;

    // Linear-zone result, carried after stage 4
    typedef struct packed {
        logic [47:0] mag;
        logic [47:0] slope;
        logic        sat;
    } lin_t;

    lin_t l4_reg, l5_reg, l6_reg, l7_reg;

    // Stage 3
    logic [4:0]        s3_e_reg;
    logic [24:0]       s3_base_reg;
    logic [24:0]       s3_frac_reg;
    logic [63:0]       s3_gx0_reg;
    logic [51:0]       s3_gx1_reg;
    logic [47:0]       s3_slope_reg;
    logic              s3_gsat_reg;
    // Stage 4
    logic signed [31:0] s4_l_reg;
    // Stage 5
    logic signed [31:0] s5_e1_reg;
    logic signed [31:0] s5_l_reg;
    // Stage 6
    logic signed [31:0] s6_e1_reg;
    logic signed [31:0] s6_e2_reg;
    // Stage 7
    logic [31:0]       s7_b1_reg;
    logic [31:0]       s7_d1_reg;
    logic [6:0]        s7_k1_reg;
    logic [31:0]       s7_b2_reg;
    logic [31:0]       s7_d2_reg;
    logic [6:0]        s7_k2_reg;
    // Stage 8
    lx_t               s8_reg;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign v_next    = {v_reg[NS-2:0], in_valid};
    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign out_data  = s8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_next[k];
            end
        end
    end

    // Stage 3: log table lookup and interpolation, linear gain times |dp|
    logic [B-1:0]      li;
    logic [RW-1:0]     lr;
    logic [AW-1:0]     li_lo;
    logic [AW-1:0]     li_hi;
    logic [24:0]       ldiff;
    logic [25+RW-1:0]  lprod;

    always_comb
    begin
        li    = in_data.m[29:RW];
        lr    = in_data.m[RW-1:0];
        li_lo = {1'b0, li};
        li_hi = li_lo + AW'(1);
        ldiff = lt_rom[li_hi] - lt_rom[li_lo];
        lprod = ldiff * lr;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c3_reg       <= '{in_data.neg, in_data.lin, in_data.zero, in_data.a};
            s3_e_reg     <= in_data.e;
            s3_base_reg  <= lt_rom[li_lo];
            s3_frac_reg  <= 25'(lprod >> RW);
            s3_gx0_reg   <= in_data.g[31:0] * in_data.x;
            s3_gx1_reg   <= in_data.g[51:32] * in_data.x;
            s3_gsat_reg  <= |in_data.g[51:48];
            s3_slope_reg <= (|in_data.g[51:48]) ? MASK48 : in_data.g[47:0];
        end
    end

    // Stage 4: assemble log2 in Q.24, finish the linear flow with clipping
    logic signed [31:0] eoff;
    logic [83:0]        gx;
    logic [59:0]        magl;
    logic [47:0]        flim3;
    logic               msat3;

    always_comb
    begin
        eoff  = $signed({27'd0, s3_e_reg}) - 32'sd16;
        gx    = {20'd0, s3_gx0_reg} + {s3_gx1_reg, 32'd0};
        magl  = gx[83:24];
        flim3 = c3_reg.neg ? FLIM_NEG : FLIM_POS;
        msat3 = magl > {12'd0, flim3};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c4_reg       <= c3_reg;
            s4_l_reg     <= (eoff <<< 24) + $signed({7'd0, s3_base_reg})
                            + $signed({7'd0, s3_frac_reg});
            l4_reg.mag   <= msat3 ? flim3 : magl[47:0];
            l4_reg.slope <= s3_slope_reg;
            l4_reg.sat   <= s3_gsat_reg | msat3;
        end
    end

    // Stage 5: scale log by the exponent, floor to Q.24
    logic signed [48:0] nl;

    assign nl = $signed({1'b0, cfg.expn}) * s4_l_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c5_reg    <= c4_reg;
            l5_reg    <= l4_reg;
            s5_e1_reg <= 32'(nl >>> 15);
            s5_l_reg  <= s4_l_reg;
        end
    end

    // Stage 6: exponent of the derivative is one less power
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            c6_reg    <= c5_reg;
            l6_reg    <= l5_reg;
            s6_e1_reg <= s5_e1_reg;
            s6_e2_reg <= s5_e1_reg - s5_l_reg;
        end
    end

    // Stage 7: exp table lookups and interpolation products
    logic [AW-1:0]    j1_lo, j1_hi, j2_lo, j2_hi;
    logic [FW-1:0]    rr1, rr2;
    logic [31:0]      ed1, ed2;
    logic [32+FW-1:0] ep1, ep2;

    always_comb
    begin
        j1_lo = {1'b0, s6_e1_reg[23:FW]};
        j1_hi = j1_lo + AW'(1);
        rr1   = s6_e1_reg[FW-1:0];
        ed1   = et_rom[j1_hi] - et_rom[j1_lo];
        ep1   = ed1 * rr1;
        j2_lo = {1'b0, s6_e2_reg[23:FW]};
        j2_hi = j2_lo + AW'(1);
        rr2   = s6_e2_reg[FW-1:0];
        ed2   = et_rom[j2_hi] - et_rom[j2_lo];
        ep2   = ed2 * rr2;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            c7_reg    <= c6_reg;
            l7_reg    <= l6_reg;
            s7_b1_reg <= et_rom[j1_lo];
            s7_d1_reg <= 32'(ep1 >> FW);
            s7_k1_reg <= s6_e1_reg[30:24];
            s7_b2_reg <= et_rom[j2_lo];
            s7_d2_reg <= 32'(ep2 >> FW);
            s7_k2_reg <= s6_e2_reg[30:24];
        end
    end

    // Stage 8: add up the mantissas
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s8_reg.neg       <= c7_reg.neg;
            s8_reg.lin       <= c7_reg.lin;
            s8_reg.zero      <= c7_reg.zero;
            s8_reg.a         <= c7_reg.a;
            s8_reg.lin_mag   <= l7_reg.mag;
            s8_reg.lin_slope <= l7_reg.slope;
            s8_reg.lin_sat   <= l7_reg.sat;
            s8_reg.m1        <= s7_b1_reg + s7_d1_reg;
            s8_reg.m2        <= s7_b2_reg + s7_d2_reg;
            s8_reg.k1        <= s7_k1_reg;
            s8_reg.k2        <= s7_k2_reg;
        end
    end

endmodule

FILE: rtl/plf_back.sv
// ----------------------------------------------------------------------------
// plf_back
// Four stages: split products of density*C with both mantissas, scaling
// shifts with clipping, zone select and the output register.
// ----------------------------------------------------------------------------
module plf_back
    import plf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lx_t                in_data,
    input  cfg_t               cfg,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] mass_flow,
    output logic        [47:0] flow_slope,
    output logic               saturated
);

    localparam int NS = 4;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    // Fields carried to the final select
    typedef struct packed {
        logic        neg;
        logic        lin;
        logic        zero;
        logic [47:0] lin_mag;
        logic [47:0] lin_slope;
        logic        lin_sat;
        logic [6:0]  k1;
        logic [6:0]  k2;
    } side_t;

    side_t s9_side_reg, s10_side_reg, s11_side_reg;

    logic [63:0]  s9_pa_lo_reg;
    logic [55:0]  s9_pa_hi_reg;
    logic [47:0]  s9_mn_reg;
    logic [55:0]  s9_a_reg;

    logic [87:0]  s10_prod1_reg;
    logic [63:0]  s10_ll_reg;
    logic [47:0]  s10_lh_reg;
    logic [55:0]  s10_hl_reg;
    logic [39:0]  s10_hh_reg;

    logic [47:0]  s11_mag_reg;
    logic         s11_msat_reg;
    logic [103:0] s11_prod2_reg;

    logic signed [47:0] flow_reg;
    logic [47:0]        slope_reg;
    logic               sat_reg;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign v_next     = {v_reg[NS-2:0], in_valid};
    assign in_ready   = en[0];
    assign out_valid  = v_reg[NS-1];
    assign mass_flow  = flow_reg;
    assign flow_slope = slope_reg;
    assign saturated  = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_next[k];
            end
        end
    end

    // Stage 9: density*C times flow mantissa in halves, mantissa times n
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s9_side_reg  <= '{in_data.neg, in_data.lin, in_data.zero, in_data.lin_mag,
                              in_data.lin_slope, in_data.lin_sat, in_data.k1, in_data.k2};
            s9_pa_lo_reg <= in_data.a[31:0] * in_data.m1;
            s9_pa_hi_reg <= in_data.a[55:32] * in_data.m1;
            s9_mn_reg    <= in_data.m2 * cfg.expn;
            s9_a_reg     <= in_data.a;
        end
    end

    // Stage 10: sum the flow product, four partials of the slope product
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s10_side_reg  <= s9_side_reg;
            s10_prod1_reg <= {24'd0, s9_pa_lo_reg} + {s9_pa_hi_reg, 32'd0};
            s10_ll_reg    <= s9_a_reg[31:0] * s9_mn_reg[31:0];
            s10_lh_reg    <= s9_a_reg[31:0] * s9_mn_reg[47:32];
            s10_hl_reg    <= s9_a_reg[55:32] * s9_mn_reg[31:0];
            s10_hh_reg    <= s9_a_reg[55:32] * s9_mn_reg[47:32];
        end
    end

    // Stage 11: scale and clip the flow, sum the slope product
    logic [6:0]  sh1;
    logic [87:0] f_shift;
    logic [47:0] flim;
    logic        fsat;

    always_comb
    begin
        sh1     = 7'd50 - s10_side_reg.k1;
        f_shift = s10_prod1_reg >> sh1;
        flim    = s10_side_reg.neg ? FLIM_NEG : FLIM_POS;
        fsat    = f_shift > {40'd0, flim};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s11_side_reg  <= s10_side_reg;
            s11_mag_reg   <= fsat ? flim : f_shift[47:0];
            s11_msat_reg  <= fsat;
            s11_prod2_reg <= {40'd0, s10_ll_reg}
                             + {24'd0, s10_lh_reg, 32'd0}
                             + {16'd0, s10_hl_reg, 32'd0}
                             + {s10_hh_reg, 64'd0};
        end
    end

    // Stage 12: scale and clip the slope, pick the zone, apply the sign
    logic [6:0]   sh2;
    logic [103:0] s_shift;
    logic         ssat;
    logic [47:0]  mag_sel;
    logic [47:0]  slope_sel;
    logic         sat_sel;

    always_comb
    begin
        sh2     = 7'd57 - s11_side_reg.k2;
        s_shift = s11_prod2_reg >> sh2;
        ssat    = s_shift > {56'd0, MASK48};
        if (s11_side_reg.lin)
        begin
            mag_sel   = s11_side_reg.lin_mag;
            slope_sel = s11_side_reg.lin_slope;
            sat_sel   = s11_side_reg.lin_sat;
        end
        else if (s11_side_reg.zero)
        begin
            mag_sel   = 48'd0;
            slope_sel = MASK48;
            sat_sel   = 1'b1;
        end
        else
        begin
            mag_sel   = s11_mag_reg;
            slope_sel = ssat ? MASK48 : s_shift[47:0];
            sat_sel   = s11_msat_reg | ssat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            flow_reg  <= s11_side_reg.neg ? $signed(48'd0 - mag_sel) : $signed(mag_sel);
            slope_reg <= slope_sel;
            sat_reg   <= sat_sel;
        end
    end

endmodule

FILE: rtl/power_law_flow_with_linear_zone.sv
// ----------------------------------------------------------------------------
// power_law_flow_with_linear_zone
// Mass flow and its derivative for a power-law flow element with a linear
// zone near zero pressure, fully pipelined.
// ----------------------------------------------------------------------------
//  port       dir   beat contents
//  flow_in    sink  pressure_diff (Q16.16 Pa), fluid_density (Q4.20)
//  flow_out   src   mass_flow (Q24.24), flow_slope (Q16.32), saturated
//  apb        slv   flow_coeff @0x00, flow_exponent @0x08,
//                   linear_threshold @0x10, linear_slope @0x18
//
// One beat per cycle sustained while flow_out is ready, through twelve register
// stages (2 front, 6 log/exp, 4 back), the last being the output register.
// Each stage loads when it is empty or the stage after it loads, so bubbles
// close up and a stalled output holds only the stages behind it.
// Reset clears every stage valid bit and loads the register defaults.
// ----------------------------------------------------------------------------
module power_law_flow_with_linear_zone
    import plf_pkg::*;
#(
    parameter int POW_TABLE_INDEX_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    plf_in_if.sink            flow_in,
    plf_out_if.source         flow_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    cfg_t   cfg;
    front_t fr_data;
    logic   fr_valid;
    logic   fr_ready;
    lx_t    lx_data;
    logic   lx_valid;
    logic   lx_ready;

    // Register file
    plf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Magnitude, products, normalize
    plf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (flow_in.valid),
        .in_ready      (flow_in.ready),
        .pressure_diff (flow_in.pressure_diff),
        .fluid_density (flow_in.fluid_density),
        .cfg           (cfg),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_data      (fr_data)
    );

    // Log2, exponent scaling, exp2
    plf_logexp #(
        .POW_TABLE_INDEX_BITS (POW_TABLE_INDEX_BITS)
    ) u_logexp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .cfg       (cfg),
        .out_valid (lx_valid),
        .out_ready (lx_ready),
        .out_data  (lx_data)
    );

    // Final products, clipping, output register
    plf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (lx_valid),
        .in_ready   (lx_ready),
        .in_data    (lx_data),
        .cfg        (cfg),
        .out_valid  (flow_out.valid),
        .out_ready  (flow_out.ready),
        .mass_flow  (flow_out.mass_flow),
        .flow_slope (flow_out.flow_slope),
        .saturated  (flow_out.saturated)
    );

endmodule
